### hdl/ls_pkg.sv
// Shared types and constants for the linear symbol table.
// Used by every module of the block but ls_ram; depends on nothing.
`default_nettype none

package ls_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = CNT_W + 1;
    localparam int OCC_W = 6;
    localparam int KEY_W = 256;
    localparam int KIND_W = 128;
    localparam int SIZE_W = 32;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_SEARCH  = 2'd1,
        OP_DISPLAY = 2'd2,
        OP_DELETE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_FOUND    = 3'd2,
        ST_MISSING  = 3'd3,
        ST_DELETED  = 3'd4,
        ST_LISTED   = 3'd5,
        ST_EMPTY    = 3'd6
    } t_status;

    typedef struct packed {
        logic        [KEY_W-1:0]  key;
        logic        [KIND_W-1:0] kind;
        logic signed [SIZE_W-1:0] size;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

    // Low bits of the entry count as reported on the result port.
    function automatic logic [OCC_W-1:0] occ_of(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+OCC_W-1:0] wide;
        wide = {{OCC_W{1'b0}}, cnt};
        return wide[OCC_W-1:0];
    endfunction

endpackage

`default_nettype wire

### hdl/linear_symbol_table_core.sv
// Top level of the linear symbol table: entry RAM, name comparator, sequencer.
// Depends on ls_pkg, ls_ram, ls_match and ls_ctrl.
`default_nettype none

// The table keeps up to TABLE_DEPTH symbols in insertion order in one RAM
// with a single registered read port, and one comparator checks one entry
// a cycle. An insert writes the RAM, unless the table is full, as the word
// is taken. A search walks the entries from the first until a match or the
// end of the table. A delete makes the same walk and on a hit moves every
// later entry down one place, as each move reads the next entry and writes
// it back one place lower. A display delivers one word per cycle after a
// first read. The block takes no new word until all words of the current
// one have been handed to the result register; a held result stalls a
// display and the final word of every other operation.
module linear_symbol_table_core
    import ls_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_operation,
    input  wire logic [63:0]        i_key_word0,
    input  wire logic [63:0]        i_key_word1,
    input  wire logic [63:0]        i_key_word2,
    input  wire logic [63:0]        i_key_word3,
    input  wire logic [63:0]        i_kind_word0,
    input  wire logic [63:0]        i_kind_word1,
    input  wire logic signed [31:0] i_entry_size,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [2:0]              o_status,
    output logic [63:0]             o_out_key0,
    output logic [63:0]             o_out_key1,
    output logic [63:0]             o_out_key2,
    output logic [63:0]             o_out_key3,
    output logic [63:0]             o_out_kind0,
    output logic [63:0]             o_out_kind1,
    output logic signed [31:0]      o_out_size,
    output logic [OCC_W-1:0]        o_occupancy,
    output logic                    o_last
);

    t_entry           in_ent;
    t_entry           rd_ent;
    t_entry           out_ent;
    t_mem_req         req;
    t_status          status;
    logic [KEY_W-1:0] key;
    logic             hit;
    logic [ENTRY_W-1:0] rd_bits;

    assign in_ent.key  = {i_key_word3, i_key_word2, i_key_word1, i_key_word0};
    assign in_ent.kind = {i_kind_word1, i_kind_word0};
    assign in_ent.size = i_entry_size;
    assign rd_ent      = t_entry'(rd_bits);

    ls_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (req.we),
        .i_waddr(req.waddr),
        .i_wdata(req.wdata),
        .i_re   (req.re),
        .i_raddr(req.raddr),
        .o_rdata(rd_bits)
    );

    ls_match u_match (
        .i_key    (key),
        .i_ent_key(rd_ent.key),
        .o_hit    (hit)
    );

    ls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_op       (t_op'(i_operation)),
        .i_ent      (in_ent),
        .i_hit      (hit),
        .i_rd_ent   (rd_ent),
        .o_req      (req),
        .o_key      (key),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_status   (status),
        .o_ent      (out_ent),
        .o_occupancy(o_occupancy),
        .o_last     (o_last)
    );

    assign o_status    = status;
    assign o_out_key0  = out_ent.key[63:0];
    assign o_out_key1  = out_ent.key[127:64];
    assign o_out_key2  = out_ent.key[191:128];
    assign o_out_key3  = out_ent.key[255:192];
    assign o_out_kind0 = out_ent.kind[63:0];
    assign o_out_kind1 = out_ent.kind[127:64];
    assign o_out_size  = out_ent.size;

endmodule

`default_nettype wire

### hdl/ls_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package dependency.
`default_nettype none

module ls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                           i_clk,
    input  wire logic                                           i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                               i_wdata,
    input  wire logic                                           i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                               o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/ls_match.sv
// Shared name comparator: the searched key against the entry at the RAM output.
// Depends on ls_pkg.
`default_nettype none

module ls_match
    import ls_pkg::*;
(
    input  wire logic [KEY_W-1:0] i_key,
    input  wire logic [KEY_W-1:0] i_ent_key,
    output logic                  o_hit
);

    // The whole name takes part, bytes after a zero byte included.
    assign o_hit = (i_key == i_ent_key);

endmodule

`default_nettype wire

### hdl/ls_ctrl.sv
// Symbol table sequencer: walks the entry RAM one entry a cycle (a display
// only while no result is held) and holds the result register. Depends on ls_pkg.
`default_nettype none

module ls_ctrl
    import ls_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire t_op        i_op,
    input  wire t_entry     i_ent,
    input  wire logic       i_hit,
    input  wire t_entry     i_rd_ent,
    output t_mem_req        o_req,
    output logic [KEY_W-1:0] o_key,
    output logic            o_valid,
    input  wire logic       i_stall,
    output t_status         o_status,
    output t_entry          o_ent,
    output logic [OCC_W-1:0] o_occupancy,
    output logic            o_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DISP,
        S_EMIT
    } t_state;

    t_state           r_state;
    t_op              r_op;
    t_status          r_status;
    logic             r_use_ent;
    logic [IDX_W-1:0] r_j;
    logic [CNT_W-1:0] r_count;

    logic             accept;
    logic             out_free;
    logic             emit;
    logic             full;
    logic             empty;
    logic             more1;
    logic             more2;
    logic [IDX_W-1:0] next_j;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign o_stall  = (r_state != S_IDLE);
    assign out_free = !o_valid || !i_stall;
    assign emit     = out_free && ((r_state == S_DISP) || (r_state == S_EMIT));
    assign full     = (r_count >= CNT_W'(TABLE_DEPTH));
    assign empty    = (r_count == '0);
    assign next_j   = r_j + IDX_W'(1);
    // Whether entries r_j+1 and r_j+2 lie inside the table.
    assign more1    = (CMP_W'(r_j) + CMP_W'(1)) < CMP_W'(r_count);
    assign more2    = (CMP_W'(r_j) + CMP_W'(2)) < CMP_W'(r_count);

    always_comb begin
        o_req = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_op == OP_INSERT) begin
                        o_req.we    = !full;
                        o_req.waddr = r_count[IDX_W-1:0];
                        o_req.wdata = i_ent;
                    end else begin
                        o_req.re    = 1'b1;
                        o_req.raddr = '0;
                    end
                end
            end
            S_SCAN: begin
                // On a delete hit the next entry, if any, is fetched to start the shift.
                o_req.re    = more1 && (!i_hit || (r_op == OP_DELETE));
                o_req.raddr = next_j;
            end
            S_SHIFT: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_j;
                o_req.wdata = i_rd_ent;
                o_req.re    = more2;
                o_req.raddr = r_j + IDX_W'(2);
            end
            S_DISP: begin
                o_req.re    = out_free && more1;
                o_req.raddr = next_j;
            end
            default: begin
                o_req = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && !i_stall && !emit) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op      <= i_op;
                        o_key     <= i_ent.key;
                        r_j       <= '0;
                        r_use_ent <= 1'b0;
                        case (i_op)
                            OP_INSERT: begin
                                if (full) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_status <= ST_INSERTED;
                                    r_count  <= r_count + CNT_W'(1);
                                end
                                r_state <= S_EMIT;
                            end
                            OP_DISPLAY: begin
                                r_status <= ST_EMPTY;
                                r_state  <= empty ? S_EMIT : S_DISP;
                            end
                            default: begin
                                r_status <= ST_MISSING;
                                r_state  <= empty ? S_EMIT : S_SCAN;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (i_hit) begin
                        if (r_op == OP_DELETE) begin
                            if (more1) begin
                                r_state <= S_SHIFT;
                            end else begin
                                r_count  <= r_count - CNT_W'(1);
                                r_status <= ST_DELETED;
                                r_state  <= S_EMIT;
                            end
                        end else begin
                            r_status  <= ST_FOUND;
                            r_use_ent <= 1'b1;
                            r_state   <= S_EMIT;
                        end
                    end else if (more1) begin
                        r_j <= next_j;
                    end else begin
                        r_status <= ST_MISSING;
                        r_state  <= S_EMIT;
                    end
                end
                S_SHIFT: begin
                    if (more2) begin
                        r_j <= next_j;
                    end else begin
                        r_count  <= r_count - CNT_W'(1);
                        r_status <= ST_DELETED;
                        r_state  <= S_EMIT;
                    end
                end
                S_DISP: begin
                    if (out_free) begin
                        o_valid     <= 1'b1;
                        o_status    <= ST_LISTED;
                        o_ent       <= i_rd_ent;
                        o_occupancy <= occ_of(r_count);
                        o_last      <= !more1;
                        if (more1) begin
                            r_j <= next_j;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        o_valid     <= 1'b1;
                        o_status    <= r_status;
                        o_ent       <= r_use_ent ? i_rd_ent : '0;
                        o_occupancy <= occ_of(r_count);
                        o_last      <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### hdl/ls_chk.sv
// Port-level checker for the symbol table, bound to the top level.
// Depends on ls_pkg.
`default_nettype none

module ls_chk
    import ls_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_stall,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire logic [2:0]         o_status,
    input wire logic [63:0]        o_out_key0,
    input wire logic signed [31:0] o_out_size,
    input wire logic [OCC_W-1:0]   o_occupancy,
    input wire logic               o_last
);

    logic single;

    // Statuses that never carry an entry and always close their word.
    assign single = (o_status == ST_INSERTED) || (o_status == ST_FULL) ||
                    (o_status == ST_MISSING) || (o_status == ST_DELETED) ||
                    (o_status == ST_EMPTY);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_last))
        else $error("held result word changed");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("block not busy after taking a word");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && single |-> o_last && (o_out_size == 32'sd0) && (o_out_key0 == 64'd0))
        else $error("status without entry carries data or is not last");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_EMPTY) |-> (o_occupancy == '0))
        else $error("empty status with nonzero occupancy");

endmodule

bind linear_symbol_table_core ls_chk u_chk (.*);

`default_nettype wire
